FILE: sv/ucon_pkg.sv
package ucon_pkg;

    typedef logic [2:0] t_kind;

    localparam t_kind K_NOP   = 3'd0;
    localparam t_kind K_CLEAR = 3'd1;
    localparam t_kind K_READ  = 3'd2;
    localparam t_kind K_PUT   = 3'd3;
    localparam t_kind K_NL    = 3'd4;
    localparam t_kind K_CR    = 3'd5;
    localparam t_kind K_BS    = 3'd6;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [6:0] CH_BS = 7'h08;
    localparam logic [6:0] CH_LF = 7'h0A;
    localparam logic [6:0] CH_CR = 7'h0D;
    localparam logic [6:0] CH_SP = 7'h20;
    localparam logic [6:0] CH_QM = 7'h3F;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    localparam logic [7:0]  ATTR_RESET  = 8'h0F;
    localparam logic [15:0] BLANK_RESET = 16'h0F20;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  ch;
        logic [10:0] idx;
    } t_cmd;

endpackage

FILE: sv/utf8_text_console_engine.sv
// Text console engine. Raw bytes enter on the input channel (i_in_valid / o_in_ready)
// with an operation code: put byte, clear screen or read a cell. Put bytes are decoded
// as UTF-8; the resulting characters move the cursor or are written to the cell store.
// Each item yields one to three result beats on the output channel
// (o_out_valid / i_out_ready); o_last marks the final beat of an item.
// The front end decodes items into a two-entry queue, so the input keeps accepting up
// to two items while the back end works or the receiver stalls; a stalled output beat
// is held in the output register and the back end waits behind it.
// An accepted item is written into the queue; the back end pops it only while idle,
// after the last beat of the previous item is registered. A put or newline that
// scrolls first passes S_COPY and S_FILL, a clear S_FILL, a backspace S_BSW (blanking
// the cell) and an in-range read S_READ; then S_EMIT loads each beat into the output
// register whenever that register is empty or its beat is being taken.
// A scroll walks the store once, one cell per cycle, and blanks the bottom row.
// A clear writes every cell. After reset the store is blanked with attribute 0x0F
// over all ROWS*COLUMNS cells (2000 at 80x25) and o_in_ready stays low until that
// pass ends. The attribute register is written by i_cfg_we with
// i_cfg_data and should only change while the engine is idle.
module utf8_text_console_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_byte_in,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_serial_valid,
    output logic [6:0]  o_serial_byte,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic        o_scrolled,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr,
    output logic        o_last
);

    logic [7:0]     r_attr;
    logic           init_busy;
    logic           q_full;
    logic           q_push;
    ucon_pkg::t_cmd f_cmd;
    logic           q_valid;
    ucon_pkg::t_cmd q_cmd;
    logic           q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ucon_pkg::ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_data;
        end
    end

    ucon_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_byte_in    (i_byte_in),
        .i_cell_index (i_cell_index),
        .i_init_busy  (init_busy),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (f_cmd)
    );

    ucon_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    ucon_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_attr         (r_attr),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_init_busy    (init_busy),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_serial_valid (o_serial_valid),
        .o_serial_byte  (o_serial_byte),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_scrolled     (o_scrolled),
        .o_read_char    (o_read_char),
        .o_read_attr    (o_read_attr),
        .o_last         (o_last)
    );

endmodule

FILE: sv/ucon_ram.sv
module ucon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ucon_front.sv
module ucon_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_byte_in,
    input  logic [10:0]       i_cell_index,
    input  logic              i_init_busy,
    input  logic              i_q_full,
    output logic              o_push,
    output ucon_pkg::t_cmd    o_cmd
);

    logic [1:0]  r_pending;
    logic [20:0] r_accum;
    logic [1:0]  n_pending;
    logic [20:0] n_accum;
    logic        done;
    logic        accept;
    logic [6:0]  ch;

    assign o_in_ready = !i_q_full && !i_init_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    always_comb begin
        n_pending = r_pending;
        n_accum   = r_accum;
        done      = 1'b0;
        if (r_pending == 2'd0) begin
            if (i_byte_in < ucon_pkg::ASCII_LIMIT) begin
                n_accum = 21'(i_byte_in);
                done    = 1'b1;
            end else if ((i_byte_in & ucon_pkg::LEAD2_MASK) == ucon_pkg::LEAD2_CODE) begin
                n_accum   = 21'(i_byte_in[4:0]);
                n_pending = 2'd1;
            end else if ((i_byte_in & ucon_pkg::LEAD3_MASK) == ucon_pkg::LEAD3_CODE) begin
                n_accum   = 21'(i_byte_in[3:0]);
                n_pending = 2'd2;
            end else if ((i_byte_in & ucon_pkg::LEAD4_MASK) == ucon_pkg::LEAD4_CODE) begin
                n_accum   = 21'(i_byte_in[2:0]);
                n_pending = 2'd3;
            end else begin
                n_accum = 21'(ucon_pkg::CH_QM);
                done    = 1'b1;
            end
        end else if ((i_byte_in & ucon_pkg::CONT_MASK) == ucon_pkg::CONT_CODE) begin
            n_accum   = {r_accum[14:0], i_byte_in[5:0]};
            n_pending = r_pending - 2'd1;
            done      = (n_pending == 2'd0);
        end else begin
            n_pending = 2'd0;
            n_accum   = 21'(ucon_pkg::CH_QM);
            done      = 1'b1;
        end
    end

    assign ch = (n_accum < 21'(ucon_pkg::ASCII_LIMIT)) ? n_accum[6:0] : ucon_pkg::CH_QM;

    always_comb begin
        o_cmd.ch  = ch;
        o_cmd.idx = i_cell_index;
        case (i_op)
            ucon_pkg::OP_PUT: begin
                if (!done) begin
                    o_cmd.kind = ucon_pkg::K_NOP;
                end else if (ch == ucon_pkg::CH_LF) begin
                    o_cmd.kind = ucon_pkg::K_NL;
                end else if (ch == ucon_pkg::CH_CR) begin
                    o_cmd.kind = ucon_pkg::K_CR;
                end else if (ch == ucon_pkg::CH_BS) begin
                    o_cmd.kind = ucon_pkg::K_BS;
                end else begin
                    o_cmd.kind = ucon_pkg::K_PUT;
                end
            end
            ucon_pkg::OP_CLEAR: o_cmd.kind = ucon_pkg::K_CLEAR;
            ucon_pkg::OP_READ:  o_cmd.kind = ucon_pkg::K_READ;
            default:            o_cmd.kind = ucon_pkg::K_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_accum   <= 21'd0;
        end else if (accept && i_op == ucon_pkg::OP_PUT) begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
        end
    end

endmodule

FILE: sv/ucon_queue.sv
module ucon_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ucon_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output ucon_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    ucon_pkg::t_cmd r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

FILE: sv/ucon_back.sv
module ucon_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_attr,
    input  logic           i_q_valid,
    input  ucon_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_init_busy,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_serial_valid,
    output logic [6:0]     o_serial_byte,
    output logic [6:0]     o_cursor_col,
    output logic [4:0]     o_cursor_row,
    output logic           o_scrolled,
    output logic [7:0]     o_read_char,
    output logic [7:0]     o_read_attr,
    output logic           o_last
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [CW:0]   COLS_W    = (CW + 1)'(COLUMNS);
    localparam logic [RW:0]   ROWS_W    = (RW + 1)'(ROWS);
    localparam logic [CW-1:0] COL_MAX   = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_COPY = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_BSW  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    ucon_pkg::t_kind     r_kind, n_kind;
    logic [6:0]          r_ch, n_ch;
    logic                r_scr, n_scr;
    logic [7:0]          r_rc, n_rc;
    logic [7:0]          r_ra, n_ra;
    logic [1:0]          r_k, n_k;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic                r_cp_valid, n_cp_valid;
    logic [AW-1:0]       r_cp_addr, n_cp_addr;
    logic [15:0]         r_fill_data, n_fill_data;
    logic                r_init, n_init;

    logic                r_ov, n_ov;
    logic                r_o_sv, n_o_sv;
    logic [6:0]          r_o_sb, n_o_sb;
    logic [6:0]          r_o_col, n_o_col;
    logic [4:0]          r_o_row, n_o_row;
    logic                r_o_scr, n_o_scr;
    logic [7:0]          r_o_rc, n_o_rc;
    logic [7:0]          r_o_ra, n_o_ra;
    logic                r_o_last, n_o_last;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [15:0]         ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [15:0]         ram_rdata;

    logic [AW-1:0]       cur_addr;
    logic [CW:0]         col_inc;
    logic [RW:0]         row_inc;
    logic [1:0]          res_last;
    logic                ser_valid;
    logic [6:0]          ser_byte;

    ucon_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cur_addr = AW'(r_row) * COLS_A + AW'(r_col);
    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign row_inc  = {1'b0, r_row} + 1'b1;

    always_comb begin
        case (r_kind)
            ucon_pkg::K_NL: res_last = 2'd1;
            ucon_pkg::K_BS: res_last = 2'd2;
            default:        res_last = 2'd0;
        endcase
        ser_valid = 1'b0;
        ser_byte  = 7'd0;
        case (r_kind)
            ucon_pkg::K_PUT: begin
                ser_valid = 1'b1;
                ser_byte  = r_ch;
            end
            ucon_pkg::K_CR: begin
                ser_valid = 1'b1;
                ser_byte  = ucon_pkg::CH_CR;
            end
            ucon_pkg::K_NL: begin
                ser_valid = 1'b1;
                ser_byte  = (r_k == 2'd0) ? ucon_pkg::CH_CR : ucon_pkg::CH_LF;
            end
            ucon_pkg::K_BS: begin
                ser_valid = 1'b1;
                ser_byte  = (r_k == 2'd1) ? ucon_pkg::CH_SP : ucon_pkg::CH_BS;
            end
            default: begin
                ser_valid = 1'b0;
                ser_byte  = 7'd0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_kind      = r_kind;
        n_ch        = r_ch;
        n_scr       = r_scr;
        n_rc        = r_rc;
        n_ra        = r_ra;
        n_k         = r_k;
        n_ptr       = r_ptr;
        n_cp_valid  = r_cp_valid;
        n_cp_addr   = r_cp_addr;
        n_fill_data = r_fill_data;
        n_init      = r_init;
        n_ov        = r_ov && !i_out_ready;
        n_o_sv      = r_o_sv;
        n_o_sb      = r_o_sb;
        n_o_col     = r_o_col;
        n_o_row     = r_o_row;
        n_o_scr     = r_o_scr;
        n_o_rc      = r_o_rc;
        n_o_ra      = r_o_ra;
        n_o_last    = r_o_last;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = {i_attr, 1'b0, i_q_cmd.ch};
        ram_raddr   = AW'(i_q_cmd.idx);
        o_q_pop     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_kind  = i_q_cmd.kind;
                    n_ch    = i_q_cmd.ch;
                    n_scr   = 1'b0;
                    n_rc    = 8'd0;
                    n_ra    = 8'd0;
                    n_k     = 2'd0;
                    n_state = S_EMIT;
                    case (i_q_cmd.kind)
                        ucon_pkg::K_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_ptr       = '0;
                            n_fill_data = {i_attr, 1'b0, ucon_pkg::CH_SP};
                            n_state     = S_FILL;
                        end
                        ucon_pkg::K_READ: begin
                            if (32'(i_q_cmd.idx) < CELLS) begin
                                n_state = S_READ;
                            end
                        end
                        ucon_pkg::K_PUT, ucon_pkg::K_NL: begin
                            if (i_q_cmd.kind == ucon_pkg::K_PUT) begin
                                ram_we = 1'b1;
                            end
                            if (i_q_cmd.kind == ucon_pkg::K_NL || col_inc >= COLS_W) begin
                                n_col = '0;
                                if (row_inc >= ROWS_W) begin
                                    n_row      = ROW_MAX;
                                    n_scr      = 1'b1;
                                    n_ptr      = '0;
                                    n_cp_valid = 1'b0;
                                    n_state    = S_COPY;
                                end else begin
                                    n_row = row_inc[RW-1:0];
                                end
                            end else begin
                                n_col = col_inc[CW-1:0];
                            end
                        end
                        ucon_pkg::K_CR: begin
                            n_col = '0;
                        end
                        ucon_pkg::K_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end else if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                                n_col = COL_MAX;
                            end
                            n_state = S_BSW;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_COPY: begin
                ram_we    = r_cp_valid;
                ram_waddr = r_cp_addr;
                ram_wdata = ram_rdata;
                ram_raddr = r_ptr + COLS_A;
                if (r_ptr != COPY_END) begin
                    n_cp_valid = 1'b1;
                    n_cp_addr  = r_ptr;
                    n_ptr      = r_ptr + 1'b1;
                end else begin
                    n_cp_valid  = 1'b0;
                    n_fill_data = {i_attr, 1'b0, ucon_pkg::CH_SP};
                    n_state     = S_FILL;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = r_fill_data;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_EMIT;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_READ: begin
                n_rc    = ram_rdata[7:0];
                n_ra    = ram_rdata[15:8];
                n_state = S_EMIT;
            end
            S_BSW: begin
                ram_we    = 1'b1;
                ram_wdata = {i_attr, 1'b0, ucon_pkg::CH_SP};
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov     = 1'b1;
                    n_o_sv   = ser_valid;
                    n_o_sb   = ser_byte;
                    n_o_col  = 7'(r_col);
                    n_o_row  = 5'(r_row);
                    n_o_scr  = r_scr;
                    n_o_rc   = r_rc;
                    n_o_ra   = r_ra;
                    n_o_last = (r_k == res_last);
                    if (r_k == res_last) begin
                        n_k     = 2'd0;
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_col       <= '0;
            r_row       <= '0;
            r_k         <= 2'd0;
            r_ptr       <= '0;
            r_cp_valid  <= 1'b0;
            r_fill_data <= ucon_pkg::BLANK_RESET;
            r_init      <= 1'b1;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_k         <= n_k;
            r_ptr       <= n_ptr;
            r_cp_valid  <= n_cp_valid;
            r_fill_data <= n_fill_data;
            r_init      <= n_init;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_ch      <= n_ch;
        r_scr     <= n_scr;
        r_rc      <= n_rc;
        r_ra      <= n_ra;
        r_cp_addr <= n_cp_addr;
        r_o_sv    <= n_o_sv;
        r_o_sb    <= n_o_sb;
        r_o_col   <= n_o_col;
        r_o_row   <= n_o_row;
        r_o_scr   <= n_o_scr;
        r_o_rc    <= n_o_rc;
        r_o_ra    <= n_o_ra;
        r_o_last  <= n_o_last;
    end

    assign o_init_busy    = r_init;
    assign o_out_valid    = r_ov;
    assign o_serial_valid = r_o_sv;
    assign o_serial_byte  = r_o_sb;
    assign o_cursor_col   = r_o_col;
    assign o_cursor_row   = r_o_row;
    assign o_scrolled     = r_o_scr;
    assign o_read_char    = r_o_rc;
    assign o_read_attr    = r_o_ra;
    assign o_last         = r_o_last;

endmodule

FILE: sv/ucon_checker.sv
module ucon_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [7:0]  i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_op,
    input logic [7:0]  i_byte_in,
    input logic [10:0] i_cell_index,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_serial_valid,
    input logic [6:0]  o_serial_byte,
    input logic [6:0]  o_cursor_col,
    input logic [4:0]  o_cursor_row,
    input logic        o_scrolled,
    input logic [7:0]  o_read_char,
    input logic [7:0]  o_read_attr,
    input logic        o_last
);

    // Reset starts the clearing pass: nothing is offered and nothing is taken.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("output or input active right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_serial_byte)
        && $stable(o_last) && $stable(o_cursor_col) && $stable(o_cursor_row))
        else $error("stalled output beat changed");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cursor_col < COLUMNS) && (o_cursor_row < ROWS))
        else $error("cursor outside the screen");

    a_silent_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_serial_valid |-> o_serial_byte == 7'd0 && o_last)
        else $error("silent beat carries a serial byte or is not final");

    a_serial_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_serial_valid |-> o_read_char == 8'd0 && o_read_attr == 8'd0)
        else $error("serial beat carries read data");

endmodule

bind utf8_text_console_engine ucon_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ucon_checker (.*);

FILE: tb/tb_utf8_text_console_engine.sv
module tb_utf8_text_console_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLS * ROWS;
    localparam int STORE_WALK  = CELLS + 200;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int STALL_AT    = 120;
    localparam int STALL_LONG  = 600;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic       serial_valid;
        logic [6:0] serial_byte;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
        logic [7:0] read_char;
        logic [7:0] read_attr;
        logic       last;
    } t_console_beat;

    function automatic string show_beat(t_console_beat t);
        return $sformatf("serial %0b/%02h cursor %0d,%0d scrolled %0b read %02h/%02h last %0b",
                         t.serial_valid, t.serial_byte, t.cursor_col, t.cursor_row,
                         t.scrolled, t.read_char, t.read_attr, t.last);
    endfunction

    class t_console_mirror;
        logic [15:0]   cells [CELLS];
        int            col;
        int            row;
        int            pending;
        logic [20:0]   accum;
        logic [7:0]    attr;
        t_console_beat console_beats [$];
        int            mismatches;
        int            beats_seen;
        int            scrolls;
        int            clears;

        function new();
            attr = ucon_pkg::ATTR_RESET;
            foreach (cells[i]) cells[i] = ucon_pkg::BLANK_RESET;
            col = 0;
            row = 0;
            pending = 0;
            accum = '0;
            mismatches = 0;
            beats_seen = 0;
            scrolls = 0;
            clears = 0;
        endfunction

        function void blank_cells(int first, int count);
            for (int i = first; i < first + count; i++)
                cells[i] = {attr, 1'b0, ucon_pkg::CH_SP};
        endfunction

        function bit decode_byte(logic [7:0] b, output logic [20:0] code);
            code = '0;
            if (pending == 0) begin
                if (b < ucon_pkg::ASCII_LIMIT) begin
                    accum = {13'd0, b};
                end else if ((b & ucon_pkg::LEAD2_MASK) == ucon_pkg::LEAD2_CODE) begin
                    accum = {16'd0, b[4:0]};
                    pending = 1;
                    return 1'b0;
                end else if ((b & ucon_pkg::LEAD3_MASK) == ucon_pkg::LEAD3_CODE) begin
                    accum = {17'd0, b[3:0]};
                    pending = 2;
                    return 1'b0;
                end else if ((b & ucon_pkg::LEAD4_MASK) == ucon_pkg::LEAD4_CODE) begin
                    accum = {18'd0, b[2:0]};
                    pending = 3;
                    return 1'b0;
                end else begin
                    accum = {14'd0, ucon_pkg::CH_QM};
                end
            end else if ((b & ucon_pkg::CONT_MASK) == ucon_pkg::CONT_CODE) begin
                accum = {accum[14:0], b[5:0]};
                pending--;
                if (pending > 0) return 1'b0;
            end else begin
                pending = 0;
                accum = {14'd0, ucon_pkg::CH_QM};
            end
            code = accum;
            return 1'b1;
        endfunction

        function void accept_item(logic [1:0] op, logic [7:0] b, logic [10:0] idx);
            logic [6:0]    echo [3];
            int            n_echo;
            int            n;
            logic          scr;
            logic [7:0]    rchar;
            logic [7:0]    rattr;
            logic [20:0]   code;
            logic [6:0]    ch;
            t_console_beat beat;
            n_echo = 0;
            scr = 1'b0;
            rchar = '0;
            rattr = '0;
            echo[0] = '0;
            echo[1] = '0;
            echo[2] = '0;
            case (op)
                ucon_pkg::OP_PUT: begin
                    if (decode_byte(b, code)) begin
                        ch = (code < 21'd128) ? code[6:0] : ucon_pkg::CH_QM;
                        if (ch == ucon_pkg::CH_LF) begin
                            col = 0;
                            row++;
                        end else if (ch == ucon_pkg::CH_CR) begin
                            col = 0;
                        end else if (ch == ucon_pkg::CH_BS) begin
                            if (col > 0) begin
                                col--;
                            end else if (row > 0) begin
                                row--;
                                col = COLS - 1;
                            end
                            cells[row * COLS + col] = {attr, 1'b0, ucon_pkg::CH_SP};
                        end else begin
                            cells[row * COLS + col] = {attr, 1'b0, ch};
                            col++;
                        end
                        if (ch == ucon_pkg::CH_BS) begin
                            echo[0] = ucon_pkg::CH_BS;
                            echo[1] = ucon_pkg::CH_SP;
                            echo[2] = ucon_pkg::CH_BS;
                            n_echo = 3;
                        end else begin
                            if (col >= COLS) begin
                                col = 0;
                                row++;
                            end
                            if (row >= ROWS) begin
                                for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
                                blank_cells(CELLS - COLS, COLS);
                                row = ROWS - 1;
                                scr = 1'b1;
                                scrolls++;
                            end
                            if (ch == ucon_pkg::CH_LF) begin
                                echo[n_echo] = ucon_pkg::CH_CR;
                                n_echo++;
                            end
                            echo[n_echo] = ch;
                            n_echo++;
                        end
                    end
                end
                ucon_pkg::OP_CLEAR: begin
                    blank_cells(0, CELLS);
                    col = 0;
                    row = 0;
                    clears++;
                end
                ucon_pkg::OP_READ: begin
                    if (idx < CELLS) begin
                        rchar = cells[idx][7:0];
                        rattr = cells[idx][15:8];
                    end
                end
                default: ;
            endcase
            n = (n_echo > 0) ? n_echo : 1;
            for (int k = 0; k < n; k++) begin
                beat.serial_valid = (n_echo > 0);
                beat.serial_byte  = (n_echo > 0) ? echo[k] : 7'd0;
                beat.cursor_col   = 7'(col);
                beat.cursor_row   = 5'(row);
                beat.scrolled     = scr;
                beat.read_char    = rchar;
                beat.read_attr    = rattr;
                beat.last         = (k == n - 1);
                console_beats.push_back(beat);
            end
        endfunction

        function void check_beat(t_console_beat got);
            t_console_beat want;
            beats_seen++;
            if (console_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %s", show_beat(got));
                return;
            end
            want = console_beats.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("beat %0d mismatch", beats_seen);
                    $display("  expected %s", show_beat(want));
                    $display("  actual   %s", show_beat(got));
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = '0;
    logic [7:0]  i_byte_in = '0;
    logic [10:0] i_cell_index = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_serial_valid;
    logic [6:0]  o_serial_byte;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_row;
    logic        o_scrolled;
    logic [7:0]  o_read_char;
    logic [7:0]  o_read_attr;
    logic        o_last;

    t_console_mirror mirror;
    int              items_sent = 0;
    int              attr_values = 1;
    int              cycle_count = 0;
    bit              steady_in = 1'b0;
    bit              steady_out = 1'b0;

    utf8_text_console_engine #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_byte_in     (i_byte_in),
        .i_cell_index  (i_cell_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_serial_valid(o_serial_valid),
        .o_serial_byte (o_serial_byte),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_row  (o_cursor_row),
        .o_scrolled    (o_scrolled),
        .o_read_char   (o_read_char),
        .o_read_attr   (o_read_attr),
        .o_last        (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_count);
            $display("utf8_text_console_engine regression: fail");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [7:0] b, logic [10:0] idx);
        int gap;
        gap = steady_in ? 0 : int'($urandom_range(0, 10));
        if ($urandom_range(0, 15) == 0) steady_in = !steady_in;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_byte_in    <= b;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        mirror.accept_item(op, b, idx);
        if (op != OP_UNUSED) items_sent++;
    endtask

    task automatic put_byte(logic [7:0] b);
        send_item(ucon_pkg::OP_PUT, b, 11'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(logic [10:0] idx);
        send_item(ucon_pkg::OP_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic put_utf8(bit broken);
        int         len;
        int         cont;
        logic [7:0] lead;
        logic [7:0] tail;
        len = int'($urandom_range(2, 4));
        lead = 8'($urandom_range(0, 255));
        case (len)
            2: lead = {3'b110, lead[4:0]};
            3: lead = {4'b1110, lead[3:0]};
            default: lead = {5'b11110, lead[2:0]};
        endcase
        cont = broken ? int'($urandom_range(0, len - 2)) : len - 1;
        put_byte(lead);
        repeat (cont) put_byte({2'b10, 6'($urandom_range(0, 63))});
        if (broken) begin
            tail = 8'($urandom_range(0, 255));
            if (tail[7:6] == 2'b10) tail[7] = 1'b0;
            put_byte(tail);
        end
    endtask

    task automatic random_sequence();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 38) begin
            put_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 46) begin
            put_byte({1'b0, ucon_pkg::CH_LF});
        end else if (pick < 50) begin
            put_byte({1'b0, ucon_pkg::CH_BS});
        end else if (pick < 52) begin
            put_byte({1'b0, ucon_pkg::CH_CR});
        end else if (pick < 62) begin
            put_utf8(1'b0);
        end else if (pick < 66) begin
            put_utf8(1'b1);
        end else if (pick < 71) begin
            put_byte(8'($urandom_range(0, 255)));
        end else if (pick < 83) begin
            if ($urandom_range(0, 9) == 0) read_cell(11'($urandom_range(CELLS, 2047)));
            else read_cell(11'($urandom_range(0, CELLS - 1)));
        end else if (pick < 87) begin
            send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
        end else if (pick < 88) begin
            send_item(ucon_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)));
        end else if (pick < 91) begin
            repeat ($urandom_range(4, 26)) put_byte({1'b0, ucon_pkg::CH_LF});
        end else if (pick < 93) begin
            repeat ($urandom_range(20, 85)) put_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else begin
            put_byte(8'($urandom_range(0, 31)));
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (mirror.console_beats.size() != 0) @(posedge i_clk);
        repeat (STORE_WALK) @(posedge i_clk);
    endtask

    task automatic write_attribute(logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror.attr = value;
        attr_values++;
    endtask

    initial begin : result_sink
        t_console_beat got;
        int            hold;
        repeat (12) @(posedge i_clk);
        forever begin
            if (mirror.beats_seen == STALL_AT) begin
                hold = STALL_LONG;
            end else begin
                hold = steady_out ? 0 : int'($urandom_range(0, 10));
            end
            if ($urandom_range(0, 15) == 0) steady_out = !steady_out;
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = {o_serial_valid, o_serial_byte, o_cursor_col, o_cursor_row,
                   o_scrolled, o_read_char, o_read_attr, o_last};
            mirror.check_beat(got);
        end
    end

    initial begin : stimulus
        logic [7:0] attrs [3];
        mirror = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        read_cell(11'd0);
        read_cell(11'd2047);
        put_byte({1'b0, ucon_pkg::CH_BS});
        put_byte(8'h41);
        put_byte(8'h00);
        put_byte({1'b0, ucon_pkg::CH_LF});
        put_byte({1'b0, ucon_pkg::CH_CR});
        put_byte({1'b0, ucon_pkg::CH_BS});
        put_byte(8'hC3);
        put_byte(8'hA9);
        put_byte(8'hE2);
        put_byte(8'h82);
        put_byte(8'hAC);
        put_byte(8'hF0);
        put_byte(8'h9F);
        put_byte(8'h98);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'hFF);
        put_byte(8'hC3);
        put_byte(8'h41);
        put_byte(8'hC1);
        put_byte(8'h81);
        put_byte(8'hC0);
        put_byte(8'h8A);
        put_byte(8'hE2);
        send_item(ucon_pkg::OP_CLEAR, 8'h00, 11'd0);
        put_byte(8'h82);
        put_byte(8'hAC);
        send_item(OP_UNUSED, 8'hFF, 11'h7FF);
        read_cell(11'd1999);
        settle();

        attrs[0] = 8'hFF;
        attrs[1] = 8'h00;
        attrs[2] = 8'($urandom_range(1, 254));
        for (int p = 0; p < 3; p++) begin
            write_attribute(attrs[p]);
            while (items_sent < 110 + 85 * p) random_sequence();
            settle();
        end

        $display("%0d items under %0d attribute values gave %0d checked beats",
                 items_sent, attr_values, mirror.beats_seen);
        $display("the screen scrolled %0d times and was cleared %0d times; %0d mismatches",
                 mirror.scrolls, mirror.clears, mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.console_beats.size() == 0) begin
            $display("utf8_text_console_engine regression: pass");
        end else begin
            $display("utf8_text_console_engine regression: fail");
        end
        $finish;
    end

endmodule
